@@ hdl/lzw_pkg.sv @@
// Shared types and constants of the LZW encoder.
`default_nettype none
package lzw_pkg;

	localparam int CODE_W  = 12;
	localparam int KEY_W   = 20;
	localparam int EPOCH_W = 4;
	localparam int NEXT_W  = 13;
	localparam int SLOT_DW = EPOCH_W + KEY_W + CODE_W;
	localparam logic [31:0] HASH_K = 32'h9E37_79B1;
	localparam logic [EPOCH_W-1:0] EPOCH_CLR = '0;
	localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_in;
	} lzw_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_out;
	} lzw_out_t;

	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic [KEY_W-1:0]   key;
		logic [CODE_W-1:0]  code;
	} lzw_slot_t;

endpackage
`default_nettype wire

@@ hdl/lzw_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none
module lzw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ hdl/lzw_encoder_12bit_packed.sv @@
// Top level of the LZW encoder with 12-bit codes packed into bytes.
//
// Input channel data (data_valid / data_stall) carries one message byte per
// word plus a last-of-message flag. Output channel code (code_valid /
// code_stall) carries the packed code stream, one byte per word, two codes in
// every three bytes, big-endian; the final byte of a message has last_out set.
// A word moves at a clock edge with valid high and stall low.
//
// Each byte runs through a sequencer around the dictionary RAM: hash the
// (prefix, byte) key (multiply, then hold, then a step-wise reduction when
// HASH_SLOTS is not a power of two), then probe the slots in turn (registered
// RAM read, then compare). A miss adds 1-2 output bytes and an insert.
// Only one byte is in work at a time; data_stall is high while it runs.
// The output register decouples the sides: the next byte is taken while a
// finished word still waits, and emission pauses while that word is held by
// code_stall.
//
// The dictionary is cleared per message by an epoch mark held in each slot.
// After reset, and after every fifteenth message, a clearing pass writes all
// HASH_SLOTS slots, one per cycle; data_stall stays high.
`default_nettype none
module lzw_encoder_12bit_packed
	import lzw_pkg::*;
#(
	parameter int DICT_LIMIT = 3840,
	parameter int HASH_SLOTS = 8192
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    data_valid,
	output logic         data_stall,
	input  wire lzw_in_t data,
	output logic         code_valid,
	input  wire logic    code_stall,
	output lzw_out_t     code
);
	localparam int  SW   = $clog2(HASH_SLOTS);
	localparam bit  POW2 = (HASH_SLOTS & (HASH_SLOTS - 1)) == 0;
	localparam int  QB   = 25 - SW;
	localparam int  STW  = $clog2(QB + 1);
	localparam logic [NEXT_W-1:0] LIMIT = NEXT_W'(DICT_LIMIT);
	localparam logic [SW-1:0]     LAST_SLOT = SW'(HASH_SLOTS - 1);

	// follow-up once a code has been emitted
	localparam logic [1:0] POST_INS = 2'd0;
	localparam logic [1:0] POST_PRB = 2'd1;
	localparam logic [1:0] POST_FIN = 2'd2;

	typedef enum logic [13:0] {
		S_CLR    = 14'b00_0000_0000_0001,
		S_IDLE   = 14'b00_0000_0000_0010,
		S_PREFIX = 14'b00_0000_0000_0100,
		S_HMUL   = 14'b00_0000_0000_1000,
		S_HLD    = 14'b00_0000_0001_0000,
		S_HRED   = 14'b00_0000_0010_0000,
		S_PRD    = 14'b00_0000_0100_0000,
		S_PCHK   = 14'b00_0000_1000_0000,
		S_EMA    = 14'b00_0001_0000_0000,
		S_EMB    = 14'b00_0010_0000_0000,
		S_PAD    = 14'b00_0100_0000_0000,
		S_POST   = 14'b00_1000_0000_0000,
		S_STEP   = 14'b01_0000_0000_0000,
		S_FIN    = 14'b10_0000_0000_0000
	} state_t;

	state_t              state_q;
	logic                fuse_q;      // final code pending after read wait
	logic [7:0]          c_q;
	logic                last_q;
	logic [7:0]          cur_byte_q;
	logic [CODE_W-1:0]   cur_code_q;
	logic                single_q;
	logic                have_q;
	logic                half_q;
	logic [3:0]          held_q;
	logic [NEXT_W-1:0]   next_q;
	logic [CODE_W-1:0]   code_q;
	logic [1:0]          post_q;
	logic                fin_q;
	logic                ins_q;
	logic [KEY_W-1:0]    key_q;
	logic [31:0]         prod_s1;
	logic [23:0]         rem_q;
	logic [STW-1:0]      step_q;
	logic [SW-1:0]       slot_q;
	logic [SW-1:0]       clr_q;
	logic [EPOCH_W-1:0]  epoch_q;
	logic [255:0]        bct_vld_q;

	logic                ovld_q;
	lzw_out_t            obuf_q;

	// memories
	logic                dict_we;
	logic [SW-1:0]       dict_waddr;
	lzw_slot_t           dict_wdata;
	lzw_slot_t           dict_rdata;
	logic                bct_we;
	logic [CODE_W-1:0]   bct_rdata;

	logic                can_put;
	logic                put;
	lzw_out_t            put_word;
	logic [25:0]         red_lim;
	logic [23:0]         red_val;
	logic                hit;
	logic                occupied;
	logic [SW-1:0]       slot_nxt;
	logic                below;

	assign can_put    = !ovld_q || !code_stall;
	assign red_lim    = 26'(HASH_SLOTS) << step_q;
	assign red_val    = ({2'b00, rem_q} >= red_lim) ? 24'({2'b00, rem_q} - red_lim) : rem_q;
	assign occupied   = dict_rdata.epoch == epoch_q;
	assign hit        = occupied && (dict_rdata.key == key_q);
	assign slot_nxt   = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
	assign below      = next_q < LIMIT;
	assign data_stall = state_q != S_IDLE;
	assign code_valid = ovld_q;
	assign code       = obuf_q;

	lzw_ram #(.WIDTH(SLOT_DW), .DEPTH(HASH_SLOTS)) u_dict (
		.clk   (clk),
		.we    (dict_we),
		.waddr (dict_waddr),
		.wdata (dict_wdata),
		.raddr (slot_q),
		.rdata (dict_rdata)
	);

	lzw_ram #(.WIDTH(CODE_W), .DEPTH(256)) u_bct (
		.clk   (clk),
		.we    (bct_we),
		.waddr (cur_byte_q),
		.wdata (next_q[CODE_W-1:0]),
		.raddr (cur_byte_q),
		.rdata (bct_rdata)
	);

	// dictionary writes: clearing pass, or insert at the free slot found
	always_comb begin
		dict_we    = 1'b0;
		dict_waddr = slot_q;
		dict_wdata = '{epoch: epoch_q, key: key_q, code: next_q[CODE_W-1:0]};
		if (state_q == S_CLR) begin
			dict_we    = 1'b1;
			dict_waddr = clr_q;
			dict_wdata = '{epoch: EPOCH_CLR, key: '0, code: '0};
		end else if (state_q == S_PCHK) begin
			dict_we = ins_q && !occupied;
		end else if (state_q == S_POST) begin
			dict_we = (post_q == POST_INS) && below;
		end
	end

	// single-byte code handed out on demand
	always_comb begin
		bct_we = 1'b0;
		if (state_q == S_PREFIX) begin
			bct_we = !bct_vld_q[cur_byte_q];
		end else if (state_q == S_FIN && fuse_q) begin
			bct_we = single_q && !bct_vld_q[cur_byte_q];
		end
	end

	// emitted byte, high nibble first
	always_comb begin
		put      = 1'b0;
		put_word = '{out_byte: code_q[11:4], last_out: 1'b0};
		if (can_put) begin
			if (state_q == S_EMA) begin
				put = 1'b1;
				if (half_q) begin
					put_word.out_byte = {held_q, code_q[11:8]};
				end
			end else if (state_q == S_EMB) begin
				put      = 1'b1;
				put_word = '{out_byte: code_q[7:0], last_out: fin_q};
			end else if (state_q == S_PAD) begin
				put      = 1'b1;
				put_word = '{out_byte: {held_q, 4'h0}, last_out: 1'b1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (put) begin
			ovld_q <= 1'b1;
		end else if (!code_stall) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (put) begin
			obuf_q <= put_word;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			fuse_q     <= 1'b0;
			clr_q      <= '0;
			epoch_q    <= EPOCH_CLR + 1'b1;
			cur_byte_q <= '0;
			cur_code_q <= '0;
			single_q   <= 1'b1;
			have_q     <= 1'b0;
			half_q     <= 1'b0;
			held_q     <= '0;
			next_q     <= '0;
			bct_vld_q  <= '0;
			post_q     <= POST_INS;
			fin_q      <= 1'b0;
			ins_q      <= 1'b0;
			last_q     <= 1'b0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_SLOT) begin
						clr_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (data_valid) begin
						c_q    <= data.data_byte;
						last_q <= data.last_in;
						if (!have_q) begin
							cur_byte_q <= data.data_byte;
							single_q   <= 1'b1;
							have_q     <= 1'b1;
							if (data.last_in) begin
								fuse_q  <= 1'b0;
								state_q <= S_FIN;
							end
						end else if (single_q) begin
							state_q <= S_PREFIX;
						end else begin
							key_q   <= {cur_code_q, data.data_byte};
							ins_q   <= 1'b0;
							state_q <= S_HMUL;
						end
					end
				end
				S_PREFIX: begin
					if (bct_vld_q[cur_byte_q]) begin
						key_q   <= {bct_rdata, c_q};
						ins_q   <= 1'b0;
						state_q <= S_HMUL;
					end else begin
						code_q                <= next_q[CODE_W-1:0];
						bct_vld_q[cur_byte_q] <= 1'b1;
						next_q                <= next_q + 1'b1;
						post_q                <= POST_PRB;
						fin_q                 <= 1'b0;
						state_q               <= S_EMA;
					end
				end
				S_HMUL: begin
					prod_s1 <= 32'(32'(key_q) * HASH_K);
					state_q <= S_HLD;
				end
				S_HLD: begin
					rem_q  <= prod_s1[31:8];
					step_q <= STW'(QB - 1);
					if (POW2) begin
						slot_q  <= prod_s1[8 +: SW];
						state_q <= S_PRD;
					end else begin
						state_q <= S_HRED;
					end
				end
				S_HRED: begin
					rem_q  <= red_val;
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						slot_q  <= red_val[SW-1:0];
						state_q <= S_PRD;
					end
				end
				S_PRD: begin
					state_q <= S_PCHK;
				end
				S_PCHK: begin
					if (hit) begin
						if (ins_q) begin
							state_q <= S_STEP;
						end else begin
							cur_code_q <= dict_rdata.code;
							single_q   <= 1'b0;
							fuse_q     <= 1'b0;
							state_q    <= last_q ? S_FIN : S_IDLE;
						end
					end else if (!occupied) begin
						if (ins_q) begin
							next_q  <= next_q + 1'b1;
							state_q <= S_STEP;
						end else begin
							code_q  <= key_q[KEY_W-1 -: CODE_W];
							post_q  <= POST_INS;
							fin_q   <= 1'b0;
							state_q <= S_EMA;
						end
					end else begin
						slot_q  <= slot_nxt;
						state_q <= S_PRD;
					end
				end
				S_EMA: begin
					if (can_put) begin
						if (half_q) begin
							half_q  <= 1'b0;
							state_q <= S_EMB;
						end else begin
							held_q  <= code_q[3:0];
							half_q  <= 1'b1;
							state_q <= fin_q ? S_PAD : S_POST;
						end
					end
				end
				S_EMB: begin
					if (can_put) begin
						held_q  <= '0;
						state_q <= S_POST;
					end
				end
				S_PAD: begin
					if (can_put) begin
						state_q <= S_POST;
					end
				end
				S_POST: begin
					case (post_q)
						POST_INS: begin
							if (below) begin
								next_q <= next_q + 1'b1;
							end
							state_q <= S_STEP;
						end
						POST_PRB: begin
							if (below) begin
								key_q   <= {code_q, c_q};
								ins_q   <= 1'b1;
								state_q <= S_HMUL;
							end else begin
								state_q <= S_STEP;
							end
						end
						default: begin
							// message done: drop the dictionary by advancing the epoch, or by a clearing pass once it wraps
							cur_byte_q <= '0;
							cur_code_q <= '0;
							single_q   <= 1'b1;
							have_q     <= 1'b0;
							half_q     <= 1'b0;
							held_q     <= '0;
							next_q     <= '0;
							bct_vld_q  <= '0;
							fin_q      <= 1'b0;
							if (epoch_q == EPOCH_MAX) begin
								epoch_q <= EPOCH_CLR + 1'b1;
								state_q <= S_CLR;
							end else begin
								epoch_q <= epoch_q + 1'b1;
								state_q <= S_IDLE;
							end
						end
					endcase
				end
				S_STEP: begin
					cur_byte_q <= c_q;
					single_q   <= 1'b1;
					fuse_q     <= 1'b0;
					state_q    <= last_q ? S_FIN : S_IDLE;
				end
				S_FIN: begin
					// with fuse_q low, wait for the table read of the new byte
					fuse_q <= 1'b1;
					if (fuse_q) begin
						if (!single_q) begin
							code_q <= cur_code_q;
						end else if (bct_vld_q[cur_byte_q]) begin
							code_q <= bct_rdata;
						end else begin
							code_q                <= next_q[CODE_W-1:0];
							bct_vld_q[cur_byte_q] <= 1'b1;
							next_q                <= next_q + 1'b1;
						end
						fin_q   <= 1'b1;
						post_q  <= POST_FIN;
						fuse_q  <= 1'b0;
						state_q <= S_EMA;
					end
				end
				default: begin
					state_q <= S_CLR;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

@@ hdl/lzw_checker.sv @@
// Port-level checks of the LZW encoder, bound to its top level.
`default_nettype none
module lzw_checker
	import lzw_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     data_valid,
	input wire logic     data_stall,
	input wire lzw_in_t  data,
	input wire logic     code_valid,
	input wire logic     code_stall,
	input wire lzw_out_t code
);
	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && code_stall |=> code_valid && $stable(code))
		else $error("output word changed under stall");

	// closing a message keeps the block busy for the final code
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		data_valid && !data_stall && data.last_in |=> data_stall ##1 data_stall)
		else $error("input taken too early after last byte");

	// no output word is produced in the cycle of an input accept
	a_no_put_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		data_valid && !data_stall |=> !$rose(code_valid))
		else $error("output word loaded at input accept");
endmodule

bind lzw_encoder_12bit_packed lzw_checker u_lzw_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.data_valid (data_valid),
	.data_stall (data_stall),
	.data       (data),
	.code_valid (code_valid),
	.code_stall (code_stall),
	.code       (code)
);
`default_nettype wire

@@ dv/lzw_encoder_12bit_packed_tb.sv @@
// Self-checking testbench of the LZW encoder with 12-bit packed output.
`default_nettype none
module lzw_encoder_12bit_packed_tb
	import lzw_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DICT_MAX  = 3840;
	localparam int SLOT_CNT  = 8192;
	localparam int TAIL_WAIT = 200;
	localparam int HOLD_AT   = 9000;
	localparam int HOLD_LEN  = 3000;

	logic     clk;
	logic     arst_n;
	logic     data_valid;
	logic     data_stall;
	lzw_in_t  data;
	logic     code_valid;
	logic     code_stall;
	lzw_out_t code;

	lzw_encoder_12bit_packed #(
		.DICT_LIMIT (DICT_MAX),
		.HASH_SLOTS (SLOT_CNT)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_valid (data_valid),
		.data_stall (data_stall),
		.data       (data),
		.code_valid (code_valid),
		.code_stall (code_stall),
		.code       (code)
	);

	// Encoder mirror: dictionary, single-byte codes and packing phase.
	logic [31:0] mir_slot [SLOT_CNT];
	bit          mir_used [SLOT_CNT];
	logic [12:0] mir_byte_code [256];
	int unsigned mir_next;
	int unsigned mir_cur_code;
	int unsigned mir_cur_byte;
	bit          mir_single;
	bit          mir_have;
	bit          mir_half;
	int unsigned mir_nibble;

	lzw_out_t    step_bytes [8];
	int          step_n;
	lzw_out_t    pending_bytes [$];
	lzw_in_t     stim [$];
	int          errors;

	// Directed rows: a typed expectation only for single-byte messages.
	typedef struct {
		lzw_in_t    w;
		bit         typed;
		logic [7:0] b0;
		logic [7:0] b1;
	} row_t;

	row_t rows [$];

	task automatic report(input string what);
		errors++;
		$display("MISMATCH at %0t: %s", $realtime, what);
	endtask

	function automatic void add_row(input lzw_in_t w, input bit typed,
	                                input logic [7:0] b0, input logic [7:0] b1);
		row_t r;
		r.w = w;
		r.typed = typed;
		r.b0 = b0;
		r.b1 = b1;
		rows.insert(rows.size(), r);
	endfunction

	function automatic void mirror_clear();
		for (int i = 0; i < SLOT_CNT; i++) mir_used[i] = 1'b0;
		for (int i = 0; i < 256; i++) mir_byte_code[i] = '0;
		mir_next = 0;
		mir_cur_code = 0;
		mir_cur_byte = 0;
		mir_single = 1'b1;
		mir_have = 1'b0;
		mir_half = 1'b0;
		mir_nibble = 0;
	endfunction

	function automatic int unsigned hash_home(input int unsigned key);
		logic [31:0] p;
		p = key * 32'd2654435761;
		return (p >> 8) % SLOT_CNT;
	endfunction

	// Slot that holds key, or the first free one on its path.
	function automatic int unsigned slot_find(input int unsigned key, output bit hit);
		int unsigned s;
		s = hash_home(key);
		hit = 1'b0;
		for (int n = 0; n < SLOT_CNT; n++) begin
			if (!mir_used[s]) return s;
			if ((mir_slot[s] >> 12) == key) begin
				hit = 1'b1;
				return s;
			end
			s = (s + 1) % SLOT_CNT;
		end
		return 0;
	endfunction

	function automatic void emit_byte(input int unsigned b);
		step_bytes[step_n] = '{out_byte: b[7:0], last_out: 1'b0};
		step_n++;
	endfunction

	function automatic void emit_code(input int unsigned c);
		c = c & 12'hfff;
		if (mir_half) begin
			emit_byte((mir_nibble << 4) | ((c >> 8) & 4'hf));
			emit_byte(c & 8'hff);
			mir_half = 1'b0;
			mir_nibble = 0;
		end else begin
			emit_byte((c >> 4) & 8'hff);
			mir_nibble = c & 4'hf;
			mir_half = 1'b1;
		end
	endfunction

	// Code of the current string; a single byte gets its code here first.
	function automatic int unsigned string_code();
		logic [12:0] e;
		int unsigned c;
		if (!mir_single) return mir_cur_code;
		e = mir_byte_code[mir_cur_byte];
		if (e[12]) return e[11:0];
		c = mir_next & 12'hfff;
		mir_byte_code[mir_cur_byte] = {1'b1, c[11:0]};
		mir_next++;
		return c;
	endfunction

	function automatic void encode_byte(input lzw_in_t w);
		int unsigned ch;
		int unsigned prefix;
		int unsigned slot;
		int unsigned c;
		int unsigned key;
		bit known;
		bit hit;
		ch = w.data_byte;
		step_n = 0;
		hit = 1'b0;
		if (!mir_have) begin
			mir_cur_byte = ch;
			mir_single = 1'b1;
			mir_have = 1'b1;
		end else begin
			known = 1'b1;
			if (mir_single) begin
				known = mir_byte_code[mir_cur_byte][12];
				prefix = mir_byte_code[mir_cur_byte][11:0];
			end else begin
				prefix = mir_cur_code;
			end
			if (known) slot = slot_find((prefix << 8) | ch, hit);
			if (hit) begin
				mir_cur_code = mir_slot[slot] & 12'hfff;
				mir_single = 1'b0;
			end else begin
				c = string_code();
				emit_code(c);
				if (mir_next < DICT_MAX) begin
					key = (c << 8) | ch;
					slot = slot_find(key, hit);
					if (!hit) begin
						mir_slot[slot] = (key << 12) | (mir_next & 12'hfff);
						mir_used[slot] = 1'b1;
					end
					mir_next++;
				end
				mir_cur_byte = ch;
				mir_single = 1'b1;
			end
		end
		if (w.last_in) begin
			emit_code(string_code());
			if (mir_half) emit_byte(mir_nibble << 4);
			step_bytes[step_n-1].last_out = 1'b1;
			mirror_clear();
		end
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Build the stimulus: directed table first, then random messages.
	initial begin
		int len;
		int alpha;
		// single-byte messages at both byte extremes: code 0, then pad
		add_row('{8'h00, 1'b1}, 1'b1, 8'h00, 8'h00);
		add_row('{8'hff, 1'b1}, 1'b1, 8'h00, 8'h00);
		// repeated byte: strings of growing length
		for (int i = 0; i < 7; i++) add_row('{8'h41, i == 6}, 1'b0, 8'h00, 8'h00);
		// ABABABA pattern, the final code completes a held nibble
		for (int i = 0; i < 7; i++)
			add_row('{i[0] ? 8'h42 : 8'h41, i == 6}, 1'b0, 8'h00, 8'h00);
		// two-byte message, distinct extremes
		add_row('{8'h00, 1'b0}, 1'b0, 8'h00, 8'h00);
		add_row('{8'hff, 1'b1}, 1'b0, 8'h00, 8'h00);
		// walking bits, one message
		for (int i = 0; i < 8; i++) add_row('{8'h01 << i, i == 7}, 1'b0, 8'h00, 8'h00);
		foreach (rows[i]) stim.insert(stim.size(), rows[i].w);
		// random messages: mostly a small alphabet so strings repeat
		while (stim.size() < 300) begin
			len = $urandom_range(1, 40);
			alpha = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(2, 6);
			for (int i = 0; i < len; i++) begin
				lzw_in_t w;
				w.data_byte = (alpha == 256) ? 8'($urandom) : 8'($urandom_range(0, alpha - 1)) + 8'h61;
				w.last_in = (i == len - 1);
				stim.insert(stim.size(), w);
			end
		end
	end

	// Sender: bursts of random length with gaps between them.
	int stim_idx;
	int burst_left;
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_valid <= 1'b0;
			data       <= '0;
			stim_idx   <= 0;
			burst_left <= 20;
			gap_left   <= 0;
		end else if (!data_valid || !data_stall) begin
			if (gap_left > 0) begin
				gap_left   <= gap_left - 1;
				data_valid <= 1'b0;
			end else if (stim_idx < stim.size()) begin
				data       <= stim[stim_idx];
				data_valid <= 1'b1;
				stim_idx   <= stim_idx + 1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 30);
					gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				data_valid <= 1'b0;
			end
		end
	end

	// Receiver: own stall pattern, plus one long hold-off to fill the block.
	int rx_cycle;
	int hold_left;
	int stall_mode;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_stall <= 1'b0;
			rx_cycle   <= 0;
			hold_left  <= 0;
			stall_mode <= 0;
		end else begin
			rx_cycle <= rx_cycle + 1;
			if (rx_cycle == HOLD_AT) hold_left <= HOLD_LEN;
			else if (hold_left > 0) hold_left <= hold_left - 1;
			if (rx_cycle % 500 == 0) stall_mode <= $urandom_range(0, 2);
			if (hold_left > 0 || rx_cycle == HOLD_AT)
				code_stall <= 1'b1;
			else case (stall_mode)
				0: code_stall <= 1'b0;
				1: code_stall <= ($urandom_range(0, 3) == 0);
				default: code_stall <= ($urandom_range(0, 1) == 0);
			endcase
		end
	end

	// Predict on every accepted input word.
	int row_idx;
	always @(posedge clk) begin
		if (arst_n && data_valid && !data_stall) begin
			encode_byte(data);
			if (row_idx < rows.size() && rows[row_idx].typed) begin
				if (step_n != 2 || step_bytes[0].out_byte != rows[row_idx].b0 ||
				    step_bytes[1].out_byte != rows[row_idx].b1 || !step_bytes[1].last_out)
					report($sformatf("row %0d: mirror disagrees with typed bytes", row_idx));
			end
			for (int i = 0; i < step_n; i++)
				pending_bytes.insert(pending_bytes.size(), step_bytes[i]);
			row_idx++;
		end
	end

	// Check every accepted output word against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && code_valid && !code_stall) begin
			if (pending_bytes.size() == 0) begin
				report($sformatf("unexpected word %h/%b", code.out_byte, code.last_out));
			end else begin
				lzw_out_t e;
				e = pending_bytes.pop_front();
				if (code.out_byte !== e.out_byte)
					report($sformatf("out_byte %h, want %h", code.out_byte, e.out_byte));
				if (code.last_out !== e.last_out)
					report($sformatf("last_out %b, want %b", code.last_out, e.last_out));
			end
		end
	end

	// Main sequence: reset, drain, final verdict.
	initial begin
		errors  = 0;
		row_idx = 0;
		mirror_clear();
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (stim_idx < stim.size() || data_valid) @(posedge clk);
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog: clearing passes, the hold-off and slow drain fit well inside.
	initial begin
		#10ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
`default_nettype wire

@@ files.f @@
hdl/lzw_pkg.sv
hdl/lzw_ram.sv
hdl/lzw_encoder_12bit_packed.sv
hdl/lzw_checker.sv
dv/lzw_encoder_12bit_packed_tb.sv
